FILE: rtl/dmwc_pkg.sv
// shared constants, types and microcode rom of the direct-mapped write-back cache
package dmwc_pkg;

  // address split: tag, line index, word offset
  localparam int ADDR_BITS      = 16;
  localparam int LINES          = 64;
  localparam int WORDS_PER_LINE = 128;
  localparam int IDX_BITS       = $clog2(LINES);
  localparam int OFF_BITS       = $clog2(WORDS_PER_LINE);
  localparam int TAG_BITS       = ADDR_BITS - IDX_BITS - OFF_BITS;
  localparam int LINE_ADDR_BITS = IDX_BITS + OFF_BITS;
  localparam int LINE_WORDS     = LINES * WORDS_PER_LINE;

  // backing memory
  localparam int MEM_WORDS      = 65536;
  localparam int MEM_ADDR_BITS  = $clog2(MEM_WORDS);

  // field and storage widths
  localparam int DATA_BITS      = 32;
  localparam int WORD_BITS_DEF  = 32;

  // operation codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // beat payloads
  typedef struct packed {
    logic                 operation;
    logic [ADDR_BITS-1:0] address;
    logic [DATA_BITS-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] read_data;
    logic                 was_hit;
  } rsp_t;

  // counter operations
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_ZERO = 2'd1;
  localparam logic [1:0] CNT_INC  = 2'd2;

  // line store write source
  localparam logic [1:0] LW_NONE = 2'd0;
  localparam logic [1:0] LW_FILL = 2'd1;
  localparam logic [1:0] LW_REQ  = 2'd2;

  // backing memory operation
  localparam logic [1:0] MO_NONE  = 2'd0;
  localparam logic [1:0] MO_CLEAR = 2'd1;
  localparam logic [1:0] MO_WB    = 2'd2;
  localparam logic [1:0] MO_RD    = 2'd3;

  // jump conditions
  localparam logic [2:0] C_NEXT          = 3'd0;
  localparam logic [2:0] C_ALWAYS        = 3'd1;
  localparam logic [2:0] C_NOT_ACCEPT    = 3'd2;
  localparam logic [2:0] C_NOT_CLR_LAST  = 3'd3;
  localparam logic [2:0] C_HIT           = 3'd4;
  localparam logic [2:0] C_NOT_VALID     = 3'd5;
  localparam logic [2:0] C_NOT_LINE_LAST = 3'd6;
  localparam logic [2:0] C_OUT_BLOCKED   = 3'd7;

  // program steps
  localparam int STEP_BITS = 4;
  localparam logic [STEP_BITS-1:0] ST_CLR    = 4'd0;
  localparam logic [STEP_BITS-1:0] ST_IDLE   = 4'd1;
  localparam logic [STEP_BITS-1:0] ST_TAG    = 4'd2;
  localparam logic [STEP_BITS-1:0] ST_HIT    = 4'd3;
  localparam logic [STEP_BITS-1:0] ST_VLD    = 4'd4;
  localparam logic [STEP_BITS-1:0] ST_WRD0   = 4'd5;
  localparam logic [STEP_BITS-1:0] ST_WB     = 4'd6;
  localparam logic [STEP_BITS-1:0] ST_FRD0   = 4'd7;
  localparam logic [STEP_BITS-1:0] ST_FILL   = 4'd8;
  localparam logic [STEP_BITS-1:0] ST_SETTAG = 4'd9;
  localparam logic [STEP_BITS-1:0] ST_ACC    = 4'd10;
  localparam logic [STEP_BITS-1:0] ST_CAP    = 4'd11;
  localparam logic [STEP_BITS-1:0] ST_RET    = 4'd12;

  // datapath controls of one step
  typedef struct packed {
    logic       rdy;
    logic [1:0] cnt_op;
    logic       tag_rd;
    logic       hit_ld;
    logic       rd_off;
    logic       ahead;
    logic [1:0] line_wr;
    logic [1:0] mem_op;
    logic       tag_wr;
    logic       rsp_ld;
  } ctrl_t;

  // one control word
  typedef struct packed {
    ctrl_t                ctrl;
    logic [2:0]           cond;
    logic [STEP_BITS-1:0] target;
  } ucode_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic accept;
    logic clr_last;
    logic hit;
    logic valid;
    logic line_last;
    logic out_blocked;
  } stat_t;

  // control program
  function automatic ucode_t ucode_rom(input logic [STEP_BITS-1:0] step);
    ucode_t w;
    w = '0;
    case (step)
      ST_CLR: begin
        w.ctrl.mem_op = MO_CLEAR;
        w.ctrl.cnt_op = CNT_INC;
        w.cond        = C_NOT_CLR_LAST;
        w.target      = ST_CLR;
      end
      ST_IDLE: begin
        w.ctrl.rdy    = 1'b1;
        w.ctrl.cnt_op = CNT_ZERO;
        w.cond        = C_NOT_ACCEPT;
        w.target      = ST_IDLE;
      end
      ST_TAG: begin
        w.ctrl.tag_rd = 1'b1;
      end
      ST_HIT: begin
        w.ctrl.hit_ld = 1'b1;
        w.cond        = C_HIT;
        w.target      = ST_ACC;
      end
      ST_VLD: begin
        w.cond   = C_NOT_VALID;
        w.target = ST_FRD0;
      end
      ST_WRD0: begin
        w.ctrl.ahead = 1'b0;
      end
      ST_WB: begin
        w.ctrl.mem_op = MO_WB;
        w.ctrl.ahead  = 1'b1;
        w.ctrl.cnt_op = CNT_INC;
        w.cond        = C_NOT_LINE_LAST;
        w.target      = ST_WB;
      end
      ST_FRD0: begin
        w.ctrl.mem_op = MO_RD;
        w.ctrl.cnt_op = CNT_ZERO;
      end
      ST_FILL: begin
        w.ctrl.line_wr = LW_FILL;
        w.ctrl.mem_op  = MO_RD;
        w.ctrl.ahead   = 1'b1;
        w.ctrl.cnt_op  = CNT_INC;
        w.cond         = C_NOT_LINE_LAST;
        w.target       = ST_FILL;
      end
      ST_SETTAG: begin
        w.ctrl.tag_wr = 1'b1;
      end
      ST_ACC: begin
        w.ctrl.rd_off  = 1'b1;
        w.ctrl.line_wr = LW_REQ;
      end
      ST_CAP: begin
        w.ctrl.rd_off = 1'b1;
        w.ctrl.rsp_ld = 1'b1;
        w.cond        = C_OUT_BLOCKED;
        w.target      = ST_CAP;
      end
      ST_RET: begin
        w.cond   = C_ALWAYS;
        w.target = ST_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/dmwc_stream_if.sv
// valid/ready channel carrying one payload per beat
interface dmwc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/dmwc_sequencer.sv
// microcode sequencer: step counter, control rom and conditional jumps
module dmwc_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  dmwc_pkg::stat_t stat,
  output dmwc_pkg::ctrl_t ctrl
);
  import dmwc_pkg::*;

  logic [STEP_BITS-1:0] upc;
  logic [STEP_BITS-1:0] upc_next;
  ucode_t               word;
  logic                 take;

  // fetch control word
  assign word = ucode_rom(upc);
  assign ctrl = word.ctrl;

  // jump condition
  always_comb begin
    case (word.cond)
      C_NEXT:          take = 1'b0;
      C_ALWAYS:        take = 1'b1;
      C_NOT_ACCEPT:    take = !stat.accept;
      C_NOT_CLR_LAST:  take = !stat.clr_last;
      C_HIT:           take = stat.hit;
      C_NOT_VALID:     take = !stat.valid;
      C_NOT_LINE_LAST: take = !stat.line_last;
      C_OUT_BLOCKED:   take = stat.out_blocked;
      default:         take = 1'b0;
    endcase
  end

  assign upc_next = take ? word.target : upc + STEP_BITS'(1);

  // step counter, starts with the memory clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ST_CLR;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

FILE: rtl/dmwc_datapath.sv
// cache datapath: request registers, tag/valid store, line store, backing memory, result register
module dmwc_datapath #(
  parameter int WORD_BITS = dmwc_pkg::WORD_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  dmwc_pkg::ctrl_t ctrl,
  output dmwc_pkg::stat_t stat,
  dmwc_stream_if.sink     req,
  dmwc_stream_if.source   rsp
);
  import dmwc_pkg::*;

  // request registers
  logic                 op_r;
  logic [TAG_BITS-1:0]  tag_r;
  logic [IDX_BITS-1:0]  idx_r;
  logic [OFF_BITS-1:0]  off_r;
  logic [WORD_BITS-1:0] wdata_r;
  logic                 accept;

  // step counter for line copies and the clearing pass
  logic [MEM_ADDR_BITS-1:0] cnt;
  logic [OFF_BITS-1:0]      cnt_off;
  logic [OFF_BITS-1:0]      cnt_rd;

  // tags and valid bits
  logic [LINES-1:0]    line_valid;
  logic [TAG_BITS-1:0] tag_mem [LINES];
  logic [TAG_BITS-1:0] tag_q;
  logic                hit_now;
  logic                hit_r;

  // line store
  logic [WORD_BITS-1:0]      line_mem [LINE_WORDS];
  logic [WORD_BITS-1:0]      line_q;
  logic [LINE_ADDR_BITS-1:0] line_raddr;
  logic [LINE_ADDR_BITS-1:0] line_waddr;
  logic [WORD_BITS-1:0]      line_wdata;
  logic                      line_we;

  // backing memory
  logic [WORD_BITS-1:0]     mem [MEM_WORDS];
  logic [WORD_BITS-1:0]     mem_q;
  logic [MEM_ADDR_BITS-1:0] mem_addr;
  logic [WORD_BITS-1:0]     mem_wdata;
  logic                     mem_we;

  // result register
  logic                 out_valid;
  logic                 out_blocked;
  logic [DATA_BITS-1:0] out_data;
  logic                 out_hit;

  // request capture
  assign req.ready = ctrl.rdy;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= req.payload.operation;
      tag_r   <= req.payload.address[ADDR_BITS-1 -: TAG_BITS];
      idx_r   <= req.payload.address[OFF_BITS +: IDX_BITS];
      off_r   <= req.payload.address[OFF_BITS-1:0];
      wdata_r <= WORD_BITS'(req.payload.write_data);
    end
  end

  // counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (ctrl.cnt_op)
        CNT_ZERO: cnt <= '0;
        CNT_INC:  cnt <= cnt + MEM_ADDR_BITS'(1);
        default:  cnt <= cnt;
      endcase
    end
  end

  assign cnt_off = cnt[OFF_BITS-1:0];
  // reads run one word ahead of writes inside copy loops
  assign cnt_rd  = ctrl.ahead ? cnt_off + OFF_BITS'(1) : cnt_off;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
    end else if (ctrl.tag_wr) begin
      line_valid[idx_r] <= 1'b1;
    end
  end

  // tag store
  always_ff @(posedge clk) begin
    if (ctrl.tag_wr) begin
      tag_mem[idx_r] <= tag_r;
    end
    if (ctrl.tag_rd) begin
      tag_q <= tag_mem[idx_r];
    end
  end

  assign hit_now = line_valid[idx_r] && (tag_q == tag_r);

  always_ff @(posedge clk) begin
    if (ctrl.hit_ld) begin
      hit_r <= hit_now;
    end
  end

  // line store port control
  assign line_raddr = ctrl.rd_off ? {idx_r, off_r} : {idx_r, cnt_rd};

  always_comb begin
    case (ctrl.line_wr)
      LW_FILL: begin
        line_we    = 1'b1;
        line_waddr = {idx_r, cnt_off};
        line_wdata = mem_q;
      end
      LW_REQ: begin
        line_we    = (op_r == OP_WRITE);
        line_waddr = {idx_r, off_r};
        line_wdata = wdata_r;
      end
      default: begin
        line_we    = 1'b0;
        line_waddr = {idx_r, off_r};
        line_wdata = wdata_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_waddr] <= line_wdata;
    end
    line_q <= line_mem[line_raddr];
  end

  // backing memory port control
  always_comb begin
    case (ctrl.mem_op)
      MO_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = cnt;
        mem_wdata = '0;
      end
      MO_WB: begin
        mem_we    = 1'b1;
        mem_addr  = MEM_ADDR_BITS'({tag_q, idx_r, cnt_off});
        mem_wdata = line_q;
      end
      MO_RD: begin
        mem_we    = 1'b0;
        mem_addr  = MEM_ADDR_BITS'({tag_r, idx_r, cnt_rd});
        mem_wdata = line_q;
      end
      default: begin
        mem_we    = 1'b0;
        mem_addr  = MEM_ADDR_BITS'({tag_r, idx_r, cnt_rd});
        mem_wdata = line_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_q <= mem[mem_addr];
  end

  // result register, freed by the rsp beat
  assign out_blocked = out_valid && !rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.rsp_ld && !out_blocked) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rsp_ld && !out_blocked) begin
      out_data <= (op_r == OP_WRITE) ? DATA_BITS'(wdata_r) : DATA_BITS'(line_q);
      out_hit  <= hit_r;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.payload.read_data = out_data;
  assign rsp.payload.was_hit   = out_hit;

  // status to the sequencer
  assign stat.accept      = accept;
  assign stat.clr_last    = (cnt == '1);
  assign stat.hit         = hit_now;
  assign stat.valid       = line_valid[idx_r];
  assign stat.line_last   = (cnt_off == '1);
  assign stat.out_blocked = out_blocked;

endmodule

FILE: rtl/direct_mapped_writeback_cache_unit.sv
// hit: tag read, hit check, line access, result capture; next req waits for the capture
// miss on an empty line adds a refill (one backing read per word of the refill)
// miss on a valid line adds a whole-line write-back, then the refill
// the single backing memory port sets the miss cost; the result waits in a register
// after rst the backing memory is cleared one word a cycle, 65536 words, req not ready
module direct_mapped_writeback_cache_unit #(
  parameter int WORD_BITS = dmwc_pkg::WORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  dmwc_stream_if.sink   req,
  dmwc_stream_if.source rsp
);
  import dmwc_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // control program
  dmwc_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // storage and data movement
  dmwc_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .stat (stat),
    .req  (req),
    .rsp  (rsp)
  );

endmodule
